FILE: hw/rtl/tdli_pkg.sv
// Package: shared widths, codes and sequencer states of the delay line core.
`default_nettype none
package tdli_pkg;

  localparam int TIME_W = 48;
  localparam int VAL_W  = 32;
  localparam int CHAN_W = 3;
  localparam int DIFF_W = TIME_W + 1;
  localparam int TGT_W  = TIME_W + 2;
  localparam int PART_W = 25;
  localparam int LOW_W  = DIFF_W - PART_W;
  localparam int PROD_W = VAL_W + PART_W;
  localparam int ACC_W  = 82;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam logic STAT_OK        = 1'b0;
  localparam logic STAT_NEG_DELAY = 1'b1;

  typedef logic [TIME_W-1:0]        time_t;
  typedef logic signed [VAL_W-1:0]  val_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_OLDEST,
    ST_NEWEST,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_PICK0W,
    ST_PICK1W,
    ST_EQCHK,
    ST_MUL,
    ST_ACC,
    ST_NORM,
    ST_HALF,
    ST_OVF,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tdli_in_if.sv
// Interfaces: input sample/read channel and result channel.
`default_nettype none
interface tdli_in_if import tdli_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [CHAN_W-1:0]        channel;
  logic [TIME_W-1:0]        sample_time;
  logic signed [VAL_W-1:0]  sample_value;
  logic signed [TIME_W-1:0] delay_amount;
  logic [TIME_W-1:0]        max_delay;

  modport source (output valid, func, channel, sample_time, sample_value,
                  delay_amount, max_delay, input ready);
  modport sink   (input valid, func, channel, sample_time, sample_value,
                  delay_amount, max_delay, output ready);
endinterface

interface tdli_out_if import tdli_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] delayed_value;
  logic                    status;

  modport source (output valid, delayed_value, status, input ready);
  modport sink   (input valid, delayed_value, status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tdli_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module tdli_ram #(
  parameter int W = 32,
  parameter int D = 512
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/tdli_div.sv
// Restoring divider: 80-bit dividend by 48-bit divisor, 32 quotient bits, one bit a cycle.
`default_nettype none
module tdli_div import tdli_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] num_hi,
  input  wire logic [VAL_W-1:0]  num_lo,
  input  wire logic [TIME_W-1:0] den,
  output logic                   done,
  output logic [VAL_W-1:0]       quot
);
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] den_r, den_nxt;
  logic [VAL_W-1:0]  lo_r, lo_nxt;
  logic [VAL_W-1:0]  q_r, q_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [TIME_W:0]   trial;
  logic              ge;

  // one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, lo_r[VAL_W-1]};
    ge       = trial >= {1'b0, den_r};
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = num_hi;
      lo_nxt  = num_lo;
      den_nxt = den;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? TIME_W'(trial - {1'b0, den_r}) : TIME_W'(trial);
      lo_nxt  = {lo_r[VAL_W-2:0], 1'b0};
      q_nxt   = {q_r[VAL_W-2:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

FILE: hw/rtl/timestamped_delay_line_interp_core.sv
// Top level: multi-channel timestamped delay line with linear interpolation.
// One transaction at a time. A store writes the new entry, then runs a binary search with
// one time-memory read per step. A read goes through ring reads, the search, four partial
// products and the divider, and can stall on the result channel.
// Reset (rst_n, synchronous) empties all rings and clears start_time; the sample memories
// are not cleared, stale entries are never read.
`default_nettype none
module timestamped_delay_line_interp_core import tdli_pkg::*; #(
  parameter int CHANNELS = 8,
  parameter int DEPTH    = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  tdli_in_if.sink                in_ch,
  tdli_out_if.source             out_ch,
  input  wire logic              cfg_we,
  input  wire logic [TIME_W-1:0] cfg_wdata
);
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int MEM_D = CHANNELS * DEPTH;
  localparam int AW    = $clog2(MEM_D);

  // ring position helpers
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] hd,
                                                input logic [CNT_W-1:0] k);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(hd) + (CNT_W+1)'(k);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return IDX_W'(s);
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [CH_W-1:0]  ch,
                                              input logic [IDX_W-1:0] hd,
                                              input logic [CNT_W-1:0] k);
    return AW'(ch) * AW'(DEPTH) + AW'(wrap_idx(hd, k));
  endfunction

  state_t state_r, state_nxt;

  logic [TIME_W-1:0] st_r;
  logic              func_r, func_nxt;
  logic              oor_r, oor_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  time_t             now_r, now_nxt;
  val_t              val_r, val_nxt;
  logic signed [TIME_W-1:0] delay_r, delay_nxt;
  time_t             maxd_r, maxd_nxt;

  logic [IDX_W-1:0]  head_r [CHANNELS];
  logic [CNT_W-1:0]  count_r [CHANNELS];
  logic              upd_en;
  logic [IDX_W-1:0]  upd_head;
  logic [CNT_W-1:0]  upd_cnt;

  logic [IDX_W-1:0]  cur_head_r, cur_head_nxt;
  logic [CNT_W-1:0]  cur_n_r, cur_n_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, i_r, i_nxt;
  logic signed [TGT_W-1:0] tgt_r, tgt_nxt;

  time_t t0_r, t0_nxt, t1_r, t1_nxt, ts_r, ts_nxt;
  val_t  v0_r, v0_nxt, v1_r, v1_nxt;
  logic signed [DIFF_W-1:0] a_r, a_nxt, b_r, b_nxt, den_r, den_nxt;
  logic [1:0]               step_r, step_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [ACC_W-1:0]         mag_r, mag_nxt;
  logic [TIME_W-1:0]        dmag_r, dmag_nxt;
  logic                     negq_r, negq_nxt;

  val_t res_r, res_nxt;
  logic stat_r, stat_nxt;
  logic out_valid_r, out_valid_nxt;
  val_t out_val_r, out_val_nxt;
  logic out_stat_r, out_stat_nxt;

  // memory ports
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [TIME_W-1:0] t_rdata;
  logic [VAL_W-1:0] v_rdata;

  // divider hookup
  logic             div_start, div_done;
  logic [VAL_W-1:0] div_quot;

  // scratch
  logic [CNT_W-1:0]         cnt_c;
  logic [IDX_W-1:0]         hd_c;
  logic                     full_c;
  logic signed [TGT_W-1:0]  tcmp;
  logic [CNT_W-1:0]         lo_c, hi_c, off_c;
  logic                     stop_c;
  logic signed [DIFF_W-1:0] dsel;
  val_t                     vsel;
  logic signed [PART_W-1:0] part;
  logic signed [ACC_W-1:0]  pext;

  tdli_ram #(.W(TIME_W), .D(MEM_D)) u_time_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(now_r),
    .raddr(mem_raddr), .rdata(t_rdata)
  );

  tdli_ram #(.W(VAL_W), .D(MEM_D)) u_value_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(val_r),
    .raddr(mem_raddr), .rdata(v_rdata)
  );

  tdli_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num_hi(mag_r[TIME_W+VAL_W-1:VAL_W]), .num_lo(mag_r[VAL_W-1:0]),
    .den(dmag_r), .done(div_done), .quot(div_quot)
  );

  // sequencer: next state, datapath updates, memory and ring control
  always_comb begin
    state_nxt    = state_r;
    func_nxt     = func_r;
    oor_nxt      = oor_r;
    ch_nxt       = ch_r;
    now_nxt      = now_r;
    val_nxt      = val_r;
    delay_nxt    = delay_r;
    maxd_nxt     = maxd_r;
    cur_head_nxt = cur_head_r;
    cur_n_nxt    = cur_n_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    i_nxt        = i_r;
    tgt_nxt      = tgt_r;
    t0_nxt       = t0_r;
    t1_nxt       = t1_r;
    ts_nxt       = ts_r;
    v0_nxt       = v0_r;
    v1_nxt       = v1_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    den_nxt      = den_r;
    step_nxt     = step_r;
    prod_nxt     = prod_r;
    acc_nxt      = acc_r;
    mag_nxt      = mag_r;
    dmag_nxt     = dmag_r;
    negq_nxt     = negq_r;
    res_nxt      = res_r;
    stat_nxt     = stat_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt  = out_val_r;
    out_stat_nxt = out_stat_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_raddr    = '0;
    upd_en       = 1'b0;
    upd_head     = '0;
    upd_cnt      = '0;
    div_start    = 1'b0;
    in_ch.ready  = 1'b0;

    cnt_c  = count_r[ch_r];
    hd_c   = head_r[ch_r];
    full_c = (cnt_c == CNT_W'(DEPTH));
    tcmp   = TGT_W'({2'b00, t_rdata});
    lo_c   = lo_r;
    hi_c   = hi_r;
    if (tcmp > tgt_r) hi_c = i_r;
    else              lo_c = i_r;
    stop_c = (tcmp == tgt_r) || ((CNT_W+1)'(hi_c) <= (CNT_W+1)'(lo_c) + 1'b1);
    off_c  = lo_c - 1'b1;
    dsel   = step_r[1] ? b_r : a_r;
    vsel   = step_r[1] ? v1_r : v0_r;
    part   = step_r[0] ? dsel[DIFF_W-1:LOW_W] : PART_W'({1'b0, dsel[LOW_W-1:0]});
    pext   = ACC_W'(prod_r);

    // result register drains independently of the sequencer
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          func_nxt  = in_ch.func;
          oor_nxt   = 32'(in_ch.channel) >= CHANNELS;
          ch_nxt    = CH_W'(in_ch.channel);
          now_nxt   = in_ch.sample_time;
          val_nxt   = in_ch.sample_value;
          delay_nxt = in_ch.delay_amount;
          maxd_nxt  = in_ch.max_delay;
          stat_nxt  = STAT_OK;
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (func_r == FUNC_STORE) begin
          if (oor_r || now_r < st_r) begin
            state_nxt = ST_IDLE;
          end else begin
            // append, overwriting the oldest entry when full
            mem_we    = 1'b1;
            mem_waddr = slot_addr(ch_r, hd_c, full_c ? '0 : cnt_c);
            upd_en    = 1'b1;
            upd_cnt   = full_c ? cnt_c : cnt_c + 1'b1;
            upd_head  = full_c ? wrap_idx(hd_c, CNT_W'(1)) : hd_c;
            cur_head_nxt = upd_head;
            cur_n_nxt    = upd_cnt;
            lo_nxt    = '0;
            hi_nxt    = upd_cnt;
            tgt_nxt   = TGT_W'({2'b00, now_r}) - TGT_W'({2'b00, maxd_r}) + 1'b1;
            state_nxt = ST_SRCH_RD;
          end
        end else begin
          cur_head_nxt = hd_c;
          cur_n_nxt    = cnt_c;
          ts_nxt       = now_r - time_t'(delay_r);
          if (oor_r || now_r <= st_r) begin
            res_nxt   = val_r;
            state_nxt = ST_OUT;
          end else if (delay_r[TIME_W-1]) begin
            res_nxt   = '0;
            stat_nxt  = STAT_NEG_DELAY;
            state_nxt = ST_OUT;
          end else if (cnt_c == '0) begin
            res_nxt   = val_r;
            state_nxt = ST_OUT;
          end else if ({2'b00, now_r} <= {2'b00, st_r} + {2'b00, time_t'(delay_r)}) begin
            // still inside the initial window: oldest entry
            mem_raddr = slot_addr(ch_r, hd_c, '0);
            state_nxt = ST_OLDEST;
          end else begin
            mem_raddr = slot_addr(ch_r, hd_c, cnt_c - 1'b1);
            state_nxt = ST_NEWEST;
          end
        end
      end

      ST_OLDEST: begin
        res_nxt   = v_rdata;
        state_nxt = ST_OUT;
      end

      ST_NEWEST: begin
        t0_nxt = t_rdata;
        v0_nxt = v_rdata;
        if (ts_r > t_rdata) begin
          // between newest entry and the current input
          t1_nxt    = now_r;
          v1_nxt    = val_r;
          state_nxt = ST_EQCHK;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = cur_n_r;
          tgt_nxt   = TGT_W'({2'b00, ts_r});
          state_nxt = ST_SRCH_RD;
        end
      end

      // binary search, one time-memory read per step
      ST_SRCH_RD: begin
        i_nxt     = CNT_W'(((CNT_W+1)'(lo_r) + (CNT_W+1)'(hi_r)) >> 1);
        mem_raddr = slot_addr(ch_r, cur_head_r, i_nxt);
        state_nxt = ST_SRCH_CMP;
      end

      ST_SRCH_CMP: begin
        lo_nxt = lo_c;
        hi_nxt = hi_c;
        if (!stop_c) begin
          state_nxt = ST_SRCH_RD;
        end else if (func_r == FUNC_STORE) begin
          // drop all but one entry older than the horizon
          if (lo_c != '0) begin
            upd_en   = 1'b1;
            upd_head = wrap_idx(cur_head_r, off_c);
            upd_cnt  = cur_n_r - off_c;
          end
          state_nxt = ST_IDLE;
        end else begin
          mem_raddr = slot_addr(ch_r, cur_head_r, lo_c);
          state_nxt = ST_PICK0W;
        end
      end

      ST_PICK0W: begin
        t0_nxt = t_rdata;
        v0_nxt = v_rdata;
        if (lo_r + 1'b1 == cur_n_r) begin
          res_nxt   = v_rdata;
          state_nxt = ST_OUT;
        end else begin
          mem_raddr = slot_addr(ch_r, cur_head_r, lo_r + 1'b1);
          state_nxt = ST_PICK1W;
        end
      end

      ST_PICK1W: begin
        t1_nxt    = t_rdata;
        v1_nxt    = v_rdata;
        state_nxt = ST_EQCHK;
      end

      ST_EQCHK: begin
        a_nxt    = DIFF_W'({1'b0, t1_r}) - DIFF_W'({1'b0, ts_r});
        b_nxt    = DIFF_W'({1'b0, ts_r}) - DIFF_W'({1'b0, t0_r});
        den_nxt  = DIFF_W'({1'b0, t1_r}) - DIFF_W'({1'b0, t0_r});
        acc_nxt  = '0;
        step_nxt = '0;
        if (t0_r == ts_r) begin
          res_nxt   = v0_r;
          state_nxt = ST_OUT;
        end else if (t1_r == ts_r) begin
          res_nxt   = v1_r;
          state_nxt = ST_OUT;
        end else if (t1_r == t0_r) begin
          res_nxt   = v0_r;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_MUL;
        end
      end

      // v0*(t1-ts) + v1*(ts-t0) from four 32x25 partial products
      ST_MUL: begin
        prod_nxt  = vsel * part;
        state_nxt = ST_ACC;
      end

      ST_ACC: begin
        acc_nxt   = acc_r + (step_r[0] ? (pext <<< LOW_W) : pext);
        step_nxt  = step_r + 1'b1;
        state_nxt = (step_r == 2'd3) ? ST_NORM : ST_MUL;
      end

      ST_NORM: begin
        mag_nxt   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
        dmag_nxt  = den_r[DIFF_W-1] ? TIME_W'(-den_r) : TIME_W'(den_r);
        negq_nxt  = acc_r[ACC_W-1] ^ den_r[DIFF_W-1];
        state_nxt = ST_HALF;
      end

      ST_HALF: begin
        // round half away from zero on the magnitude
        mag_nxt   = mag_r + ACC_W'(dmag_r >> 1);
        state_nxt = ST_OVF;
      end

      ST_OVF: begin
        if (mag_r[ACC_W-1:VAL_W] >= (ACC_W-VAL_W)'(dmag_r)) begin
          res_nxt   = negq_r ? val_t'(32'h8000_0000) : val_t'(32'h7FFF_FFFF);
          state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          if (negq_r) begin
            res_nxt = (div_quot > 32'h8000_0000) ? val_t'(32'h8000_0000)
                                                 : val_t'(-div_quot);
          end else begin
            res_nxt = div_quot[VAL_W-1] ? val_t'(32'h7FFF_FFFF) : val_t'(div_quot);
          end
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_r;
          out_stat_nxt  = stat_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        head_r[c]  <= '0;
        count_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        st_r <= cfg_wdata;
      end
      if (upd_en) begin
        head_r[ch_r]  <= upd_head;
        count_r[ch_r] <= upd_cnt;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    oor_r      <= oor_nxt;
    ch_r       <= ch_nxt;
    now_r      <= now_nxt;
    val_r      <= val_nxt;
    delay_r    <= delay_nxt;
    maxd_r     <= maxd_nxt;
    cur_head_r <= cur_head_nxt;
    cur_n_r    <= cur_n_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    i_r        <= i_nxt;
    tgt_r      <= tgt_nxt;
    t0_r       <= t0_nxt;
    t1_r       <= t1_nxt;
    ts_r       <= ts_nxt;
    v0_r       <= v0_nxt;
    v1_r       <= v1_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    den_r      <= den_nxt;
    step_r     <= step_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    mag_r      <= mag_nxt;
    dmag_r     <= dmag_nxt;
    negq_r     <= negq_nxt;
    res_r      <= res_nxt;
    stat_r     <= stat_nxt;
    out_val_r  <= out_val_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.delayed_value = out_val_r;
  assign out_ch.status        = out_stat_r;

endmodule
`default_nettype wire
